// File: src/tlsh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlsh_pkg;

  // Counter width; the count outputs always show the low OUT_CNT_W bits.
  localparam int CNT_W     = 32;
  localparam int OUT_CNT_W = 32;
  localparam int DATA_W    = 16;
  localparam int IDX_W     = 3;
  // Width for comparing a tick count against the 16-bit loosen delay.
  localparam int CMP_W     = (CNT_W > DATA_W) ? CNT_W : DATA_W;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] intv_t;

  localparam cnt_t CNT_MAX = '1;

  typedef enum logic [IDX_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_SLIDE_NORM = 3'd1,
    REG_SLIDE_ELEV = 3'd2,
    REG_SLIDE_FAST = 3'd3,
    REG_THR_ONE    = 3'd4,
    REG_THR_TWO    = 3'd5,
    REG_LOOSEN     = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    LVL_NORMAL   = 2'd0,
    LVL_ELEVATED = 2'd1,
    LVL_FAST     = 2'd2
  } level_t;

  typedef struct packed {
    logic                     enable;
    intv_t                    norm_intv;
    intv_t                    elev_intv;
    intv_t                    fast_intv;
    logic signed [DATA_W-1:0] thr_one;
    logic signed [DATA_W-1:0] thr_two;
    intv_t                    loosen;
  } cfg_t;

  typedef struct packed {
    intv_t cur_interval;
    cnt_t  ticks;
    cnt_t  switches;
    cnt_t  fast;
    cnt_t  elevated;
    cnt_t  normal;
  } state_t;

  function automatic cnt_t sat_inc(input cnt_t c);
    return (c == CNT_MAX) ? c : cnt_t'(c + cnt_t'(1));
  endfunction

endpackage

`default_nettype wire

// File: src/tlsh_step.sv
`timescale 1ns / 1ps
`default_nettype none

// One tick of the level decision and hysteresis, purely combinational.
module tlsh_step (
  input  var tlsh_pkg::cfg_t                       cfg,
  input  var tlsh_pkg::state_t                     st,
  input  var logic signed [tlsh_pkg::DATA_W-1:0]   stat,
  output tlsh_pkg::state_t                         st_nxt,
  output tlsh_pkg::intv_t                          interval,
  output tlsh_pkg::level_t                         level,
  output logic                                     switched
);

  tlsh_pkg::intv_t target;
  tlsh_pkg::cnt_t  ticks_inc;
  logic            loosen_ok;

  always_comb begin
    st_nxt    = st;
    interval  = cfg.norm_intv;
    level     = tlsh_pkg::LVL_NORMAL;
    switched  = 1'b0;
    target    = cfg.norm_intv;
    ticks_inc = tlsh_pkg::sat_inc(st.ticks);
    loosen_ok = tlsh_pkg::CMP_W'(ticks_inc) >= tlsh_pkg::CMP_W'(cfg.loosen);
    if (cfg.enable) begin
      st_nxt.ticks = ticks_inc;
      // fast test first, so crossed thresholds need no special care
      if (stat > cfg.thr_two) begin
        target      = cfg.fast_intv;
        level       = tlsh_pkg::LVL_FAST;
        st_nxt.fast = tlsh_pkg::sat_inc(st.fast);
      end else if (stat > cfg.thr_one) begin
        target          = cfg.elev_intv;
        level           = tlsh_pkg::LVL_ELEVATED;
        st_nxt.elevated = tlsh_pkg::sat_inc(st.elevated);
      end else begin
        target        = cfg.norm_intv;
        level         = tlsh_pkg::LVL_NORMAL;
        st_nxt.normal = tlsh_pkg::sat_inc(st.normal);
      end
      // tighten at once, loosen only after the delay
      if ((target != st.cur_interval) && ((target < st.cur_interval) || loosen_ok)) begin
        st_nxt.cur_interval = target;
        st_nxt.ticks        = '0;
        st_nxt.switches     = tlsh_pkg::sat_inc(st.switches);
        switched            = 1'b1;
      end
      interval = st_nxt.cur_interval;
    end
  end

endmodule

`default_nettype wire

// File: src/three_level_slide_hysteresis.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-level slide interval controller with asymmetric hysteresis.
// Input channel (in_*): one signed Q8.8 detector statistic word per tick.
// Result channel (out_*): one word per input word, carrying the interval in
//   force, the chosen level, a switch flag and four saturating counts.
// Config channel (cfg_*): index + 16-bit data, always ready; write only while
//   the block holds no work in flight.
// Path: a word accepted on in_* passes two registers (input stage, result
//   stage) before it shows on out_*. Throughput is one word per cycle while
//   out_ready is high, set by the combinational compare + counter increment.
// Stall: when out_ready is low the result register holds, the input stage
//   fills once more, then in_ready drops; nothing is dropped or repeated.
// Reset (rst_n low, synchronous): registers take their documented defaults
//   (enabled, 100/50/30, thresholds 1.0 and 3.0, delay 50), the interval goes
//   to 100, all counts clear, and both pipeline stages empty.
// Disabled: outputs the normal interval with level 0 and counts held.
module three_level_slide_hysteresis (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [tlsh_pkg::DATA_W-1:0]   in_detector_stat,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [tlsh_pkg::DATA_W-1:0]               out_effective_interval,
  output logic [1:0]                                out_target_level,
  output logic                                      out_switched,
  output logic [tlsh_pkg::OUT_CNT_W-1:0]            out_switch_total,
  output logic [tlsh_pkg::OUT_CNT_W-1:0]            out_fast_tick_total,
  output logic [tlsh_pkg::OUT_CNT_W-1:0]            out_elevated_tick_total,
  output logic [tlsh_pkg::OUT_CNT_W-1:0]            out_normal_tick_total,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [tlsh_pkg::IDX_W-1:0]           cfg_index,
  input  wire logic [tlsh_pkg::DATA_W-1:0]          cfg_data
);

  // input stage
  logic                                s1_valid_r, s1_valid_nxt;
  logic signed [tlsh_pkg::DATA_W-1:0]  stat_r;

  // config and controller state
  tlsh_pkg::cfg_t   cfg_r, cfg_nxt;
  tlsh_pkg::state_t st_r, st_nxt;

  // result stage
  logic             out_valid_r, out_valid_nxt;
  tlsh_pkg::intv_t  res_interval_r;
  logic [1:0]       res_level_r;
  logic             res_switched_r;
  tlsh_pkg::state_t res_counts_r;

  // step outputs
  tlsh_pkg::state_t step_st;
  tlsh_pkg::intv_t  step_interval;
  tlsh_pkg::level_t step_level;
  logic             step_switched;

  logic adv;
  logic cfg_wr;

  tlsh_step u_step (
    .cfg      (cfg_r),
    .st       (st_r),
    .stat     (stat_r),
    .st_nxt   (step_st),
    .interval (step_interval),
    .level    (step_level),
    .switched (step_switched)
  );

  // the held word moves to the result register when that register frees up
  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    s1_valid_nxt = adv ? 1'b0 : s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end

    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    st_nxt  = adv ? step_st : st_r;
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (tlsh_pkg::reg_idx_t'(cfg_index))
        tlsh_pkg::REG_ENABLE: begin
          cfg_nxt.enable = cfg_data[0];
          // turning adaptation off snaps back to the normal interval
          if (!cfg_data[0]) begin
            st_nxt.cur_interval = cfg_r.norm_intv;
          end
        end
        tlsh_pkg::REG_SLIDE_NORM: cfg_nxt.norm_intv = cfg_data;
        tlsh_pkg::REG_SLIDE_ELEV: cfg_nxt.elev_intv = cfg_data;
        tlsh_pkg::REG_SLIDE_FAST: cfg_nxt.fast_intv = cfg_data;
        tlsh_pkg::REG_THR_ONE:    cfg_nxt.thr_one   = cfg_data;
        tlsh_pkg::REG_THR_TWO:    cfg_nxt.thr_two   = cfg_data;
        tlsh_pkg::REG_LOOSEN:     cfg_nxt.loosen    = cfg_data;
        default: ;  // unknown index ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r           <= 1'b0;
      out_valid_r          <= 1'b0;
      cfg_r.enable         <= 1'b1;
      cfg_r.norm_intv      <= 16'd100;
      cfg_r.elev_intv      <= 16'd50;
      cfg_r.fast_intv      <= 16'd30;
      cfg_r.thr_one        <= 16'sd256;
      cfg_r.thr_two        <= 16'sd768;
      cfg_r.loosen         <= 16'd50;
      st_r.cur_interval    <= 16'd100;
      st_r.ticks           <= '0;
      st_r.switches        <= '0;
      st_r.fast            <= '0;
      st_r.elevated        <= '0;
      st_r.normal          <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
      st_r        <= st_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stat_r <= in_detector_stat;
    end
    if (adv) begin
      res_interval_r <= step_interval;
      res_level_r    <= step_level;
      res_switched_r <= step_switched;
      res_counts_r   <= step_st;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_effective_interval  = res_interval_r;
  assign out_target_level        = res_level_r;
  assign out_switched            = res_switched_r;
  assign out_switch_total        = tlsh_pkg::OUT_CNT_W'(res_counts_r.switches);
  assign out_fast_tick_total     = tlsh_pkg::OUT_CNT_W'(res_counts_r.fast);
  assign out_elevated_tick_total = tlsh_pkg::OUT_CNT_W'(res_counts_r.elevated);
  assign out_normal_tick_total   = tlsh_pkg::OUT_CNT_W'(res_counts_r.normal);

  // a switch always restarts the tick count
  a_switch_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    adv && step_switched |=> st_r.ticks == '0)
    else $error("tick count not cleared after switch");

  // a held input word is never lost while the result stage is blocked
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(stat_r))
    else $error("input stage word lost");

  // a reported switch means the switch count is nonzero
  a_switch_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_switched_r |-> res_counts_r.switches != '0)
    else $error("switch reported without count");

endmodule

`default_nettype wire
